// ----- rtl/core/jsc_pkg.sv -----
// Shared types and constants of the job-sequence crossover unit.
// No dependencies; every other file imports this package.
package jsc_pkg;

    localparam int JOB_W      = 6;   // job index field
    localparam int POS_W      = 10;  // child position field
    localparam int USE_W      = 5;   // per-job use counter
    localparam int CFG_IDX_W  = 8;   // configuration register index
    localparam int CFG_DATA_W = 7;   // configuration write data
    localparam int IDX_W      = 8;   // common width for job numbers inside the unit

    localparam logic [USE_W-1:0] USE_LIMIT = 5'd31;

    // Request command codes
    localparam logic CMD_PAIR = 1'b0;
    localparam logic CMD_FILL = 1'b1;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_JOB_COUNT     = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MACHINE_COUNT = 8'd1;

    // Controller to datapath
    typedef struct packed {
        logic pair_read;    // latch a pair, read its job's use counter
        logic pair_commit;  // consume the position, emit when allowed
        logic scan_read;    // read the use counter of the scan job
        logic scan_step;    // scan job is satisfied, move on
        logic scan_emit;    // emit the scan job
    } t_dp_cmd;

    // Datapath to controller
    typedef struct packed {
        logic pair_ok;       // incoming pair is in phase and names a valid job
        logic fill_ok;       // fill request is in phase
        logic scan_in_range; // scan job below job count
        logic use_short;     // job just read has fewer uses than machine count
        logic out_free;      // result register can take a new result
    } t_dp_status;

endpackage

// ----- rtl/core/jsc_if.sv -----
// Valid/ready channel interfaces of the job-sequence crossover unit.
// Depends on jsc_pkg for field widths.
interface jsc_req_if
    import jsc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             command;
    logic [JOB_W-1:0] good_job;
    logic [JOB_W-1:0] weak_job;

    modport source (output valid, command, good_job, weak_job, input ready);
    modport sink   (input valid, command, good_job, weak_job, output ready);
endinterface

interface jsc_rsp_if
    import jsc_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [JOB_W-1:0] child_job;
    logic [POS_W-1:0] child_position;
    logic             child_done;

    modport source (output valid, child_job, child_position, child_done, input ready);
    modport sink   (input valid, child_job, child_position, child_done, output ready);
endinterface

interface jsc_cfg_if
    import jsc_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ----- rtl/core/job_sequence_crossover_unit.sv -----
// Top level of the job-sequence crossover unit; instantiates jsc_ctrl and jsc_dp.
// Depends on jsc_pkg and the channel interfaces in jsc_if.
//
// The unit builds one child operation-sequence vector of length
// L = job_count * machine_count from two parent vectors. Send a pair request
// (command 0) for each of the L parent positions: over the first floor(L/2)
// positions the good parent's job goes to the child, after that the weak
// parent's job goes only while that job is still short of machine_count uses.
// Once all L pairs are in, send fill requests (command 1); each one emits the
// lowest job still short of its uses, until the child holds L entries. Each
// result carries its child position, and the entry that completes the child
// carries child_done and clears the unit for the next child. Requests out of
// phase, and pairs whose relevant job is at or beyond job_count, give no
// result. Writing either configuration register also starts a fresh child;
// write only while no request is in flight. A pair request first reads the
// job's use counter from the per-job memory, then updates it and loads the
// result register. A fill request scans from the current scan job, reading
// the use memory one job at a time and stepping over each fully used job.
// The result sits in its own register, so a new request is taken while the
// previous result waits; a stalled result holds the unit only in the update
// state of a pair request and once a fill request has found its job.
module job_sequence_crossover_unit
    import jsc_pkg::*;
#(
    parameter int MAX_JOBS     = 64,
    parameter int MAX_MACHINES = 16
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    jsc_req_if.sink   i_req,
    jsc_rsp_if.source o_rsp,
    jsc_cfg_if.sink   i_cfg
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    logic       w_cfg_we;

    // Configuration writes are always taken; the user must write only while idle, the unit does not enforce it.
    assign i_cfg.ready = 1'b1;
    assign w_cfg_we    = i_cfg.valid;

    // Sequencer: owns the request handshake.
    jsc_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req_valid   (i_req.valid),
        .i_req_command (i_req.command),
        .o_req_ready   (i_req.ready),
        .i_status      (w_status),
        .o_cmd         (w_cmd)
    );

    // Datapath: counters, use memory, result register.
    jsc_dp #(
        .MAX_JOBS     (MAX_JOBS),
        .MAX_MACHINES (MAX_MACHINES)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (w_cfg_we),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .i_good_job       (i_req.good_job),
        .i_weak_job       (i_req.weak_job),
        .i_cmd            (w_cmd),
        .o_status         (w_status),
        .o_out_valid      (o_rsp.valid),
        .i_out_ready      (o_rsp.ready),
        .o_child_job      (o_rsp.child_job),
        .o_child_position (o_rsp.child_position),
        .o_child_done     (o_rsp.child_done)
    );

endmodule

// ----- rtl/core/jsc_ctrl.sv -----
// Sequencer of the job-sequence crossover unit: request handshake and
// datapath commands. Depends on jsc_pkg.
module jsc_ctrl
    import jsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_req_valid,
    input  logic       i_req_command,
    output logic       o_req_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    typedef enum logic [3:0] {
        ST_IDLE     = 4'b0001,
        ST_PAIR_UPD = 4'b0010,
        ST_SCAN_RD  = 4'b0100,
        ST_SCAN_CHK = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    assign o_req_ready = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (i_req_valid) begin
                    if (i_req_command == CMD_PAIR) begin
                        if (i_status.pair_ok) begin
                            o_cmd.pair_read = 1'b1;
                            n_state         = ST_PAIR_UPD;
                        end
                    end else if (i_status.fill_ok) begin
                        n_state = ST_SCAN_RD;
                    end
                end
            end
            ST_PAIR_UPD: begin
                // hold until the result register is free
                if (i_status.out_free) begin
                    o_cmd.pair_commit = 1'b1;
                    n_state           = ST_IDLE;
                end
            end
            ST_SCAN_RD: begin
                if (i_status.scan_in_range) begin
                    o_cmd.scan_read = 1'b1;
                    n_state         = ST_SCAN_CHK;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN_CHK: begin
                if (!i_status.use_short) begin
                    o_cmd.scan_step = 1'b1;
                    n_state         = ST_SCAN_RD;
                end else if (i_status.out_free) begin
                    o_cmd.scan_emit = 1'b1;
                    n_state         = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ----- rtl/core/jsc_dp.sv -----
// Datapath of the job-sequence crossover unit: configuration, counters,
// per-job use memory and result register. Depends on jsc_pkg.
module jsc_dp
    import jsc_pkg::*;
#(
    parameter int MAX_JOBS     = 64,
    parameter int MAX_MACHINES = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic [JOB_W-1:0]      i_good_job,
    input  logic [JOB_W-1:0]      i_weak_job,
    input  t_dp_cmd               i_cmd,
    output t_dp_status            o_status,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output logic [JOB_W-1:0]      o_child_job,
    output logic [POS_W-1:0]      o_child_position,
    output logic                  o_child_done
);

    localparam int JOBS_CAP = (MAX_JOBS < 127) ? MAX_JOBS : 127;
    localparam int MACH_CAP = (MAX_MACHINES < 31) ? MAX_MACHINES : 31;
    localparam int JC_W     = $clog2(JOBS_CAP + 1);
    localparam int MC_W     = $clog2(MACH_CAP + 1);
    localparam int LEN_W    = $clog2(JOBS_CAP * MACH_CAP + 1);
    localparam int ADDR_W   = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;

    function automatic logic [ADDR_W-1:0] to_addr(input logic [IDX_W-1:0] job);
        return job[ADDR_W-1:0];
    endfunction

    // Configuration, effective values
    logic [JC_W-1:0]  r_jc;
    logic [MC_W-1:0]  r_mc;
    logic [LEN_W-1:0] w_len;
    logic [JC_W+MC_W-1:0] w_prod;

    // Child progress
    logic [LEN_W-1:0] r_pairs;
    logic [LEN_W-1:0] r_fill;
    logic [JC_W-1:0]  r_scan;
    logic [LEN_W-1:0] n_pairs;
    logic [LEN_W-1:0] n_fill;
    logic [JC_W-1:0]  n_scan;
    logic [MAX_JOBS-1:0] r_vld;

    // Use memory and its read port
    logic [USE_W-1:0]  r_mem [MAX_JOBS];
    logic [USE_W-1:0]  r_rd_mem;
    logic              r_rd_hit;
    logic [ADDR_W-1:0] r_addr;
    logic [IDX_W-1:0]  r_job;
    logic              r_first;

    logic [LEN_W-1:0]  w_half;
    logic              w_first;
    logic [JOB_W-1:0]  w_sel_job;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [USE_W-1:0]  w_uses;
    logic              w_short;
    logic [USE_W-1:0]  w_new_uses;
    logic              w_emit;
    logic [IDX_W-1:0]  w_emit_job;
    logic              w_done;
    logic              w_cfg_hit;
    logic              w_clear;
    logic [LEN_W+POS_W-1:0] w_pos_ext;
    logic [JC_W-1:0]   n_jc;
    logic [MC_W-1:0]   n_mc;

    // Child payload register
    logic             r_out_valid;
    logic [JOB_W-1:0] r_child_job;
    logic [POS_W-1:0] r_child_position;
    logic             r_child_done;

    assign w_prod    = {{MC_W{1'b0}}, r_jc} * {{JC_W{1'b0}}, r_mc};
    assign w_len     = w_prod[LEN_W-1:0];
    assign w_half    = w_len >> 1;
    assign w_first   = (r_pairs < w_half);
    assign w_sel_job = w_first ? i_good_job : i_weak_job;

    assign w_uses  = r_rd_hit ? r_rd_mem : '0;
    assign w_short = (w_uses < r_mc);
    assign w_new_uses = (w_uses < USE_LIMIT) ? (w_uses + 1'b1) : w_uses;

    assign w_rd_en   = i_cmd.pair_read | i_cmd.scan_read;
    assign w_rd_addr = i_cmd.pair_read ? to_addr({{(IDX_W-JOB_W){1'b0}}, w_sel_job})
                                       : to_addr({{(IDX_W-JC_W){1'b0}}, r_scan});

    // only writes to a defined register restart the child
    assign w_cfg_hit  = i_cfg_we
                        && (i_cfg_index inside {CFG_JOB_COUNT, CFG_MACHINE_COUNT});
    assign w_emit     = (i_cmd.pair_commit & (r_first | w_short)) | i_cmd.scan_emit;
    assign w_emit_job = i_cmd.scan_emit ? {{(IDX_W-JC_W){1'b0}}, r_scan} : r_job;
    assign n_fill     = r_fill + 1'b1;
    assign w_done     = (n_fill == w_len);
    assign w_clear    = w_cfg_hit | (w_emit & w_done);
    assign w_pos_ext  = {{POS_W{1'b0}}, r_fill};

    assign n_pairs = r_pairs + 1'b1;
    assign n_scan  = r_scan + 1'b1;

    always_comb begin
        if (i_cfg_data == '0) begin
            n_jc = JC_W'(1);
        end else if (int'(i_cfg_data) > MAX_JOBS) begin
            n_jc = JC_W'(MAX_JOBS);
        end else begin
            n_jc = i_cfg_data[JC_W-1:0];
        end
        if (i_cfg_data[4:0] == '0) begin
            n_mc = MC_W'(1);
        end else if (int'(i_cfg_data[4:0]) > MAX_MACHINES) begin
            n_mc = MC_W'(MAX_MACHINES);
        end else begin
            n_mc = i_cfg_data[MC_W-1:0];
        end
    end

    assign o_status.pair_ok       = (r_pairs < w_len) && (r_fill < w_len)
                                    && (w_sel_job < r_jc);
    assign o_status.fill_ok       = (r_pairs >= w_len) && (r_fill < w_len);
    assign o_status.scan_in_range = (r_scan < r_jc);
    assign o_status.use_short     = w_short;
    assign o_status.out_free      = !r_out_valid || i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_jc        <= JC_W'(1);
            r_mc        <= MC_W'(1);
            r_pairs     <= '0;
            r_fill      <= '0;
            r_scan      <= '0;
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_JOB_COUNT) begin
                    r_jc <= n_jc;
                end
                if (i_cfg_index == CFG_MACHINE_COUNT) begin
                    r_mc <= n_mc;
                end
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_clear) begin
                r_pairs <= '0;
                r_fill  <= '0;
                r_scan  <= '0;
                r_vld   <= '0;
            end else begin
                if (i_cmd.pair_commit) begin
                    r_pairs <= n_pairs;
                end
                if (i_cmd.scan_step) begin
                    r_scan <= n_scan;
                end
                if (w_emit) begin
                    r_fill        <= n_fill;
                    r_vld[r_addr] <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_mem[r_addr]    <= w_new_uses;
            r_child_job      <= w_emit_job[JOB_W-1:0];
            r_child_position <= w_pos_ext[POS_W-1:0];
            r_child_done     <= w_done;
        end
        if (w_rd_en) begin
            r_rd_mem <= r_mem[w_rd_addr];
            r_rd_hit <= r_vld[w_rd_addr];
            r_addr   <= w_rd_addr;
        end
        if (i_cmd.pair_read) begin
            r_job   <= {{(IDX_W-JOB_W){1'b0}}, w_sel_job};
            r_first <= w_first;
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_child_job      = r_child_job;
    assign o_child_position = r_child_position;
    assign o_child_done     = r_child_done;

endmodule
